// ===== rtl/cmtp_pkg.sv =====
// Shared types and constants of the cubic move time planner.
`default_nettype none
package cmtp_pkg;

	localparam int PERIOD_RST = 1311;

	typedef struct packed {
		logic empty;
		logic full;
	} cmtp_fifo_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cmtp_mul_stat_t;

endpackage
`default_nettype wire

// ===== rtl/cmtp_front.sv =====
// Front end: input transaction, velocity clamp, displacement and limit check.
`default_nettype none
module cmtp_front #(
	parameter int WB = 32
) (
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [WB-1:0]           start_position,
	input  logic signed [WB-1:0]           end_position,
	input  logic signed [WB-1:0]           start_velocity,
	input  logic signed [WB-1:0]           end_velocity,
	input  logic signed [WB-1:0]           velocity_limit,
	input  cmtp_pkg::cmtp_fifo_stat_t      fstat,
	output logic                           push,
	output logic [5*WB+2:0]                entry
);

	logic              bad;
	logic              zv;
	logic signed [WB:0] nlim;
	logic signed [WB:0] plim;
	logic signed [WB-1:0] vs_c;
	logic signed [WB-1:0] ve_c;
	logic signed [WB:0] d;

	assign in_stall = fstat.full;
	assign push     = in_valid && !fstat.full;

	assign plim = (WB+1)'(velocity_limit);
	assign nlim = -plim;
	assign bad  = velocity_limit[WB-1] || (velocity_limit == '0);

	always_comb begin
		if ((WB+1)'(start_velocity) > plim) begin
			vs_c = velocity_limit;
		end else if ((WB+1)'(start_velocity) < nlim) begin
			vs_c = nlim[WB-1:0];
		end else begin
			vs_c = start_velocity;
		end
		if ((WB+1)'(end_velocity) > plim) begin
			ve_c = velocity_limit;
		end else if ((WB+1)'(end_velocity) < nlim) begin
			ve_c = nlim[WB-1:0];
		end else begin
			ve_c = end_velocity;
		end
	end

	assign zv = (vs_c == '0) && (ve_c == '0);
	assign d  = (WB+1)'(end_position) - (WB+1)'(start_position);

	assign entry = {bad, zv, end_position, vs_c, ve_c, velocity_limit, d};

endmodule
`default_nettype wire

// ===== rtl/cmtp_fifo.sv =====
// Two-entry queue between front and back end.
`default_nettype none
module cmtp_fifo #(
	parameter int EW = 163
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [EW-1:0]             wdata,
	input  logic                      pop,
	output logic [EW-1:0]             rdata,
	output cmtp_pkg::cmtp_fifo_stat_t fstat
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH+1);

	logic [EW-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign fstat.empty = (cnt_q == '0);
	assign fstat.full  = (cnt_q == CW'(DEPTH));
	assign rdata       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cmtp_mul.sv =====
// Serial shift-add signed multiplier, one operand bit per cycle.
`default_nettype none
module cmtp_mul #(
	parameter int OW = 37
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [OW-1:0]     a,
	input  logic signed [OW-1:0]     b,
	output cmtp_pkg::cmtp_mul_stat_t stat,
	output logic signed [2*OW-1:0]   prod
);

	localparam int CNTW = $clog2(OW+1);

	logic [OW-1:0]   amag;
	logic [OW-1:0]   bmag;
	logic [2*OW-1:0] ma_q;
	logic [OW-1:0]   mb_q;
	logic [2*OW-1:0] acc_q;
	logic            neg_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	assign amag = a[OW-1] ? (~a + OW'(1)) : a;
	assign bmag = b[OW-1] ? (~b + OW'(1)) : b;

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = neg_q ? $signed(~acc_q + (2*OW)'(1)) : $signed(acc_q);

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= (2*OW)'(amag);
			mb_q  <= bmag;
			acc_q <= '0;
			neg_q <= a[OW-1] ^ b[OW-1];
		end else if (busy_q) begin
			acc_q <= acc_q + (mb_q[0] ? ma_q : '0);
			ma_q  <= ma_q << 1;
			mb_q  <= mb_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(OW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cmtp_back.sv =====
// Back end: sequencer for products, square root, divisions and period rounding.
`default_nettype none
module cmtp_back #(
	parameter int WB = 32,
	parameter int FB = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [5*WB+2:0]           head,
	input  cmtp_pkg::cmtp_fifo_stat_t fstat,
	output logic                      pop,
	input  logic [WB-1:0]             period,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [WB-1:0]             move_time,
	output logic                      bad_limit
);

	localparam int MW   = WB + 5;
	localparam int PW   = 2 * MW;
	localparam int SW   = PW + 4;
	localparam int AW   = PW;
	localparam int NW   = AW + FB;
	localparam int RW   = NW + 1;
	localparam int CNTW = $clog2(WB+1);

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_PREP   = 13'b0000000000010,
		S_MULGO  = 13'b0000000000100,
		S_MULW   = 13'b0000000001000,
		S_EVAL1  = 13'b0000000010000,
		S_EVAL2  = 13'b0000000100000,
		S_CHOOSE = 13'b0000001000000,
		S_SQRT   = 13'b0000010000000,
		S_SUM    = 13'b0000100000000,
		S_DIVGO  = 13'b0001000000000,
		S_DIV    = 13'b0010000000000,
		S_PER    = 13'b0100000000000,
		S_FIN    = 13'b1000000000000
	} state_t;

	typedef enum logic [2:0] {
		OP_S2SQ,
		OP_N2,
		OP_LIM2,
		OP_U,
		OP_VV,
		OP_SUMSQ,
		OP_FINAL
	} op_t;

	state_t state_q;
	op_t    op_q;

	logic                 bad_q;
	logic                 zv_q;
	logic signed [WB-1:0] p1_q;
	logic signed [WB-1:0] vs_q;
	logic signed [WB-1:0] ve_q;
	logic signed [WB-1:0] lim_q;
	logic signed [WB:0]   d_q;
	logic signed [MW-1:0] s2_q;
	logic signed [MW-1:0] s3_q;
	logic signed [MW-1:0] sum_q;
	logic signed [PW-1:0] p_s2sq_q;
	logic signed [PW-1:0] p_n2_q;
	logic signed [PW-1:0] p_lim2_q;
	logic signed [PW-1:0] p_u_q;
	logic signed [PW-1:0] p_vv_q;
	logic signed [PW-1:0] p_sumsq_q;
	logic                 cls_neg_q;
	logic                 cls_pos_q;
	logic signed [SW-1:0] tempo_q;
	logic signed [SW-1:0] rad_q;
	logic [AW-1:0]        a_q;
	logic [SW-1:0]        b_q;
	logic [RW-1:0]        rem_q;
	logic [WB-1:0]        nlo_q;
	logic [SW-1:0]        den_q;
	logic [WB-1:0]        quo_q;
	logic [WB-1:0]        t_q;
	logic                 dph_q;
	logic                 sat_q;
	logic [CNTW-1:0]      cnt_q;
	logic [2*WB-1:0]      x_q;
	logic [WB+1:0]        srem_q;
	logic [WB-1:0]        root_q;
	logic                 oval_q;
	logic [WB-1:0]        mt_q;
	logic                 ob_q;

	logic                     mstart;
	cmtp_pkg::cmtp_mul_stat_t mstat;
	logic signed [MW-1:0]     mop_a;
	logic signed [MW-1:0]     mop_b;
	logic signed [PW-1:0]     mprod;

	logic signed [MW-1:0] vsum;
	logic signed [MW-1:0] dm;
	logic signed [MW-1:0] limm;
	logic signed [PW:0]   nval;
	logic signed [SW-1:0] uval;
	logic signed [WB+2:0] d3;
	logic [WB+2:0]        d3abs;
	logic signed [WB+2:0] pv3;
	logic [WB+2:0]        pv3abs;
	logic [WB-1:0]        vsabs;
	logic [SW-1:0]        tabs;
	logic [PW-1:0]        pabs;
	logic [WB:0]          lim2x;
	logic [WB+1:0]        srs;
	logic [WB+1:0]        strial;
	logic signed [MW-1:0] rr;
	logic signed [MW-1:0] vbase;
	logic [NW-1:0]        nfull;
	logic [RW-1:0]        drs;
	logic [RW-1:0]        dden;
	logic [WB-1:0]        rlow;
	logic                 up;
	logic [WB:0]          resw;
	logic [WB-1:0]        res;
	logic                 oload;

	assign pop    = (state_q == S_IDLE) && !fstat.empty;
	assign mstart = (state_q == S_MULGO);

	assign vsum = MW'(vs_q) + MW'(ve_q);
	assign dm   = MW'(d_q);
	assign limm = MW'(lim_q);

	always_comb begin
		unique case (op_q)
			OP_S2SQ: begin
				mop_a = s2_q;
				mop_b = s2_q;
			end
			OP_N2: begin
				mop_a = s3_q + (s3_q <<< 1);
				mop_b = MW'(vs_q);
			end
			OP_LIM2: begin
				mop_a = limm;
				mop_b = limm;
			end
			OP_U: begin
				mop_a = vsum;
				mop_b = limm;
			end
			OP_VV: begin
				mop_a = MW'(vs_q);
				mop_b = MW'(ve_q);
			end
			OP_SUMSQ: begin
				mop_a = vsum;
				mop_b = vsum;
			end
			OP_FINAL: begin
				mop_a = dm + (dm <<< 1);
				mop_b = sum_q;
			end
			default: begin
				mop_a = s2_q;
				mop_b = s2_q;
			end
		endcase
	end

	cmtp_mul #(.OW(MW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart),
		.a      (mop_a),
		.b      (mop_b),
		.stat   (mstat),
		.prod   (mprod)
	);

	assign nval   = (PW+1)'(p_n2_q) - (PW+1)'(p_s2sq_q);
	assign uval   = cls_neg_q ? -SW'(p_u_q) : SW'(p_u_q);
	assign d3     = (WB+3)'(d_q) + ((WB+3)'(d_q) <<< 1);
	assign d3abs  = d3[WB+2] ? (~d3 + (WB+3)'(1)) : d3;
	assign pv3    = ((WB+3)'(p1_q) - (WB+3)'(vs_q)) * 3;
	assign pv3abs = pv3[WB+2] ? (~pv3 + (WB+3)'(1)) : pv3;
	assign vsabs  = vs_q[WB-1] ? (~vs_q + WB'(1)) : vs_q;
	assign tabs   = tempo_q[SW-1] ? (~tempo_q + SW'(1)) : tempo_q;
	assign pabs   = mprod[PW-1] ? (~mprod + PW'(1)) : mprod;
	assign lim2x  = {lim_q, 1'b0};

	assign srs    = {srem_q[WB-1:0], x_q[2*WB-1 -: 2]};
	assign strial = {root_q, 2'b01};
	assign rr     = $signed(MW'(root_q));
	assign vbase  = (cls_neg_q ? -limm : limm) + MW'(ve_q) + MW'(vs_q);

	assign nfull = {a_q, FB'(0)};
	assign drs   = {rem_q[RW-2:0], nlo_q[WB-1]};
	assign dden  = RW'(den_q);

	assign rlow = rem_q[WB-1:0];
	assign up   = {rlow, 1'b0} >= {1'b0, period};
	assign resw = (WB+1)'(t_q) - (WB+1)'(rlow) + (up ? (WB+1)'(period) : '0);

	always_comb begin
		if (bad_q) begin
			res = '0;
		end else if (sat_q) begin
			res = '1;
		end else if ((quo_q == '0) && !up) begin
			res = period;
		end else if (resw[WB]) begin
			res = '1;
		end else begin
			res = resw[WB-1:0];
		end
	end

	assign oload = (state_q == S_FIN) && (!oval_q || !out_stall);

	assign out_valid = oval_q;
	assign move_time = mt_q;
	assign bad_limit = ob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_S2SQ;
			oval_q  <= 1'b0;
			cnt_q   <= '0;
			dph_q   <= 1'b0;
		end else begin
			if (oval_q && !out_stall && !oload) begin
				oval_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!fstat.empty) begin
						bad_q <= head[5*WB+2];
						zv_q  <= head[5*WB+1];
						p1_q  <= head[5*WB:4*WB+1];
						vs_q  <= head[4*WB:3*WB+1];
						ve_q  <= head[3*WB:2*WB+1];
						lim_q <= head[2*WB:WB+1];
						d_q   <= head[WB:0];
						sat_q <= 1'b0;
						state_q <= head[5*WB+2] ? S_FIN : S_PREP;
					end
				end
				S_PREP: begin
					s2_q    <= dm + (dm <<< 1) - (MW'(vs_q) <<< 1) - MW'(ve_q);
					s3_q    <= MW'(vs_q) + MW'(ve_q) - (dm <<< 1);
					op_q    <= OP_S2SQ;
					state_q <= S_MULGO;
				end
				S_MULGO: begin
					state_q <= S_MULW;
				end
				S_MULW: begin
					if (mstat.done) begin
						case (op_q)
							OP_S2SQ: begin
								p_s2sq_q <= mprod;
								op_q     <= OP_N2;
								state_q  <= S_MULGO;
							end
							OP_N2: begin
								p_n2_q  <= mprod;
								op_q    <= OP_LIM2;
								state_q <= S_MULGO;
							end
							OP_LIM2: begin
								p_lim2_q <= mprod;
								op_q     <= OP_U;
								state_q  <= S_MULGO;
							end
							OP_U: begin
								p_u_q   <= mprod;
								op_q    <= OP_VV;
								state_q <= S_MULGO;
							end
							OP_VV: begin
								p_vv_q  <= mprod;
								op_q    <= OP_SUMSQ;
								state_q <= S_MULGO;
							end
							OP_SUMSQ: begin
								p_sumsq_q <= mprod;
								state_q   <= S_EVAL1;
							end
							default: begin
								a_q     <= pabs;
								b_q     <= tabs;
								state_q <= S_DIVGO;
							end
						endcase
					end
				end
				S_EVAL1: begin
					cls_neg_q <= (s3_q != '0) && (nval != '0) && (nval[PW] ^ s3_q[MW-1]);
					cls_pos_q <= (s3_q != '0) && (nval != '0) && !(nval[PW] ^ s3_q[MW-1]);
					state_q   <= S_EVAL2;
				end
				S_EVAL2: begin
					tempo_q <= uval + (uval <<< 1) + SW'(p_sumsq_q) - SW'(p_vv_q);
					rad_q   <= SW'(p_lim2_q) - uval + SW'(p_vv_q);
					state_q <= S_CHOOSE;
				end
				S_CHOOSE: begin
					if (zv_q) begin
						a_q     <= AW'(d3abs);
						b_q     <= SW'(lim2x);
						state_q <= S_DIVGO;
					end else if ((tempo_q == '0) && (vs_q != '0)) begin
						a_q     <= AW'(pv3abs);
						b_q     <= SW'(vsabs);
						state_q <= S_DIVGO;
					end else if (!rad_q[SW-1] && (rad_q != '0)) begin
						x_q     <= rad_q[2*WB-1:0];
						srem_q  <= '0;
						root_q  <= '0;
						cnt_q   <= CNTW'(WB);
						state_q <= S_SQRT;
					end else begin
						a_q     <= AW'(d3abs);
						b_q     <= SW'(lim2x);
						state_q <= S_DIVGO;
					end
				end
				S_SQRT: begin
					if (srs >= strial) begin
						srem_q <= srs - strial;
						root_q <= {root_q[WB-2:0], 1'b1};
					end else begin
						srem_q <= srs;
						root_q <= {root_q[WB-2:0], 1'b0};
					end
					x_q   <= x_q << 2;
					cnt_q <= cnt_q - CNTW'(1);
					if (cnt_q == CNTW'(1)) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					sum_q   <= cls_pos_q ? (vbase - rr) : (vbase + rr);
					op_q    <= OP_FINAL;
					state_q <= S_MULGO;
				end
				S_DIVGO: begin
					if (RW'(nfull[NW-1:WB]) >= RW'(b_q)) begin
						sat_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						rem_q   <= RW'(nfull[NW-1:WB]);
						nlo_q   <= nfull[WB-1:0];
						den_q   <= b_q;
						quo_q   <= '0;
						dph_q   <= 1'b0;
						cnt_q   <= CNTW'(WB);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (drs >= dden) begin
						rem_q <= drs - dden;
						quo_q <= {quo_q[WB-2:0], 1'b1};
					end else begin
						rem_q <= drs;
						quo_q <= {quo_q[WB-2:0], 1'b0};
					end
					nlo_q <= nlo_q << 1;
					cnt_q <= cnt_q - CNTW'(1);
					if (cnt_q == CNTW'(1)) begin
						state_q <= dph_q ? S_FIN : S_PER;
					end
				end
				S_PER: begin
					t_q     <= quo_q;
					rem_q   <= '0;
					nlo_q   <= quo_q;
					den_q   <= SW'(period);
					quo_q   <= '0;
					dph_q   <= 1'b1;
					cnt_q   <= CNTW'(WB);
					state_q <= S_DIV;
				end
				S_FIN: begin
					if (oload) begin
						mt_q    <= res;
						ob_q    <= bad_q;
						oval_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_mul_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mstart |-> !mstat.busy)
		else $error("multiplier restarted while busy");

	a_mul_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mstat.done |-> (state_q == S_MULW))
		else $error("product delivered outside of wait state");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(oval_q && ob_q) |-> (mt_q == '0))
		else $error("bad limit result carries a nonzero time");

	a_good_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(oval_q && !ob_q) |-> (mt_q != '0))
		else $error("valid move time is zero");

endmodule
`default_nettype wire

// ===== rtl/cubic_move_time_planner_unit.sv =====
// Top level of the cubic move time planner: period register, front, queue and back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | in_valid / in_stall    | start/end position, start/end velocity, limit
//  output   | out_valid / out_stall  | move_time, bad_limit
//  config   | cfg_valid / cfg_ready  | control_period
//
// The time a request takes is set by the serial multiplier (six products, a seventh when a root
// is taken) and by the one-bit-per-cycle root and divider.
// A bad limit skips the arithmetic: the back end goes from idle straight to its output state.
// The two-entry queue keeps taking transactions, until it is full, while the back end works or the output stalls.
// arst_n clears all control state; the period register resets to 1311.
`default_nettype none
module cubic_move_time_planner_unit #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [WORD_BITS-1:0] start_position,
	input  logic signed [WORD_BITS-1:0] end_position,
	input  logic signed [WORD_BITS-1:0] start_velocity,
	input  logic signed [WORD_BITS-1:0] end_velocity,
	input  logic signed [WORD_BITS-1:0] velocity_limit,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [WORD_BITS-1:0]        move_time,
	output logic                        bad_limit,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [WORD_BITS-1:0]        control_period
);

	localparam int EW = 5 * WORD_BITS + 3;

	logic [WORD_BITS-1:0]      period_q;
	logic [WORD_BITS-1:0]      per_eff;
	logic                      push;
	logic                      pop;
	logic [EW-1:0]             wentry;
	logic [EW-1:0]             hentry;
	cmtp_pkg::cmtp_fifo_stat_t fstat;

	assign cfg_ready = 1'b1;
	assign per_eff   = (period_q == '0) ? WORD_BITS'(1) : period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= WORD_BITS'(cmtp_pkg::PERIOD_RST);
		end else if (cfg_valid && cfg_ready) begin
			period_q <= control_period;
		end
	end

	cmtp_front #(.WB(WORD_BITS)) u_front (
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.start_position (start_position),
		.end_position   (end_position),
		.start_velocity (start_velocity),
		.end_velocity   (end_velocity),
		.velocity_limit (velocity_limit),
		.fstat          (fstat),
		.push           (push),
		.entry          (wentry)
	);

	cmtp_fifo #(.EW(EW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wentry),
		.pop    (pop),
		.rdata  (hentry),
		.fstat  (fstat)
	);

	cmtp_back #(.WB(WORD_BITS), .FB(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (hentry),
		.fstat     (fstat),
		.pop       (pop),
		.period    (per_eff),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.move_time (move_time),
		.bad_limit (bad_limit)
	);

endmodule
`default_nettype wire
